FILE: hw/rtl/hls_color_shade_top_macros.svh
// Assertion macros for hls_color_shade_top.
`ifndef HLS_COLOR_SHADE_TOP_MACROS_SVH
`define HLS_COLOR_SHADE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HCS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcs: same-cycle check failed");
`define HCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcs: next-cycle check failed");
`else
`define HCS_ASSERT_SAME(label, clk, rst, ante, cons)
`define HCS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/hcs_pkg.sv
package hcs_pkg;

   localparam int PIX_W     = 24;
   localparam int FRAC_W    = 17;
   localparam int GAIN_W    = 16;
   localparam int HUE_W     = 16;
   localparam int DIV_NUM_W = 24;
   localparam int DIV_DEN_W = 8;
   localparam int DIV_QUO_W = 17;
   localparam int DIV_LANES = 2;
   localparam int LANE_SAT  = 0;
   localparam int LANE_HUE  = 1;
   localparam int NUM_CHAN  = 3;

   localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
   localparam logic [FRAC_W-1:0] FRAC_HALF = 17'd32768;

   localparam logic [HUE_W-1:0] DEG60  = 16'd7680;
   localparam logic [HUE_W-1:0] DEG120 = 16'd15360;
   localparam logic [HUE_W-1:0] DEG180 = 16'd23040;
   localparam logic [HUE_W-1:0] DEG240 = 16'd30720;
   localparam logic [HUE_W-1:0] DEG360 = 16'd46080;

   // ceil(2^32/255): sum*65536/510 == (sum*L_RECIP) >> 17
   localparam logic [24:0] L_RECIP     = 25'd16843010;
   // ceil(2^25/15): x/15 == (x*DIV15_RECIP) >> 25 for x < 2^21
   localparam logic [21:0] DIV15_RECIP = 22'd2236963;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

   typedef enum logic [1:0] {HUE_RED, HUE_GREEN, HUE_BLUE} hcs_hue_sel_type;
   typedef enum logic [1:0] {SEG_RISE, SEG_HIGH, SEG_FALL, SEG_LOW} hcs_seg_type;
   typedef enum logic [1:0] {CSR_LIGHT_GAIN, CSR_SAT_GAIN, CSR_LIGHTEN_MODE} hcs_csr_type;

   typedef struct packed {
      hcs_hue_sel_type    hue_sel;
      logic               neg;
      logic [FRAC_W-1:0]  light;
   } hcs_side_type;

endpackage

FILE: hw/rtl/hcs_if.sv
interface hcs_req_if import hcs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_in;
   modport source(output valid, output pixel_in, input ready);
   modport sink(input valid, input pixel_in, output ready);
endinterface

interface hcs_rsp_if import hcs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   modport source(output valid, output pixel_out, input ready);
   modport sink(input valid, input pixel_out, output ready);
endinterface

FILE: hw/rtl/hls_color_shade_top.sv
// HLS colour shader: each request is one packed RGB pixel, turned into hue,
// lightness and saturation, with lightness and saturation scaled by two Q4.12
// gains (or their distance to 1.0 in lighten mode) and converted back to RGB.
// One pixel per clock is taken unless the output stalls; the pipeline is one input
// stage, 17 stages of the two parallel restoring dividers (saturation and hue, one
// quotient bit per stage) and seven stages of scaling, mixing and byte conversion.
// A stalled output holds the whole pipeline in place. The user must write gains and
// mode through the csr port while no request is in flight; this is not enforced.
`include "hls_color_shade_top_macros.svh"

module hls_color_shade_top import hcs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   hcs_req_if.sink           req_if,
   hcs_rsp_if.source         rsp_if,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [GAIN_W-1:0] csr_wdata
);

   logic [GAIN_W-1:0] light_gain_ff, sat_gain_ff;
   logic              lighten_mode_ff;
   logic              pipe_en;

   logic                                front_valid, div_valid;
   logic [DIV_LANES-1:0][DIV_NUM_W-1:0] front_num;
   logic [DIV_LANES-1:0][DIV_DEN_W-1:0] front_den;
   logic [DIV_LANES-1:0][DIV_QUO_W-1:0] div_quo;
   hcs_side_type                        front_side, div_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_gain_ff   <= GAIN_UNITY;
         sat_gain_ff     <= GAIN_UNITY;
         lighten_mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIGHT_GAIN:   light_gain_ff   <= csr_wdata;
            CSR_SAT_GAIN:     sat_gain_ff     <= csr_wdata;
            CSR_LIGHTEN_MODE: lighten_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign pipe_en      = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = pipe_en;

   hcs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .up_valid (req_if.valid),
      .up_pixel (req_if.pixel_in),
      .dn_valid (front_valid),
      .dn_num   (front_num),
      .dn_den   (front_den),
      .dn_side  (front_side)
   );

   hcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .up_valid (front_valid),
      .up_num   (front_num),
      .up_den   (front_den),
      .up_side  (front_side),
      .dn_valid (div_valid),
      .dn_quo   (div_quo),
      .dn_side  (div_side)
   );

   hcs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .en           (pipe_en),
      .light_gain   (light_gain_ff),
      .sat_gain     (sat_gain_ff),
      .lighten_mode (lighten_mode_ff),
      .up_valid     (div_valid),
      .up_quo       (div_quo),
      .up_side      (div_side),
      .dn_valid     (rsp_if.valid),
      .dn_pixel     (rsp_if.pixel_out)
   );

   `HCS_ASSERT_SAME(a_stall_blocks_req, clock, reset, rsp_if.valid && !rsp_if.ready, !req_if.ready)
   `HCS_ASSERT_NEXT(a_div_holds_on_stall, clock, reset, div_valid && !pipe_en, div_valid)
   `HCS_ASSERT_NEXT(a_front_holds_on_stall, clock, reset, front_valid && !pipe_en, front_valid)

endmodule

FILE: hw/rtl/hcs_front.sv
module hcs_front import hcs_pkg::*; (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  up_valid,
   input  logic [PIX_W-1:0]                      up_pixel,
   output logic                                  dn_valid,
   output logic [DIV_LANES-1:0][DIV_NUM_W-1:0]   dn_num,
   output logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   dn_den,
   output hcs_side_type                          dn_side
);

   logic [7:0]      r, g, b, mx, mn, d, p, q, diff;
   logic [8:0]      sum;
   logic            grey, neg;
   logic [33:0]     l_prod;
   hcs_hue_sel_type sel;

   logic                                valid_ff;
   logic [DIV_LANES-1:0][DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_LANES-1:0][DIV_DEN_W-1:0] den_ff, den_in;
   hcs_side_type                        side_ff, side_in;

   always_comb begin
      r = up_pixel[23:16];
      g = up_pixel[15:8];
      b = up_pixel[7:0];
      mx = (r > g) ? r : g;
      if (b > mx) mx = b;
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      sum  = {1'b0, mx} + {1'b0, mn};
      d    = mx - mn;
      grey = (d == 8'd0);
      if (r == mx) begin
         sel = HUE_RED;   p = g; q = b;
      end else if (g == mx) begin
         sel = HUE_GREEN; p = b; q = r;
      end else begin
         sel = HUE_BLUE;  p = r; q = g;
      end
      neg  = (p < q);
      diff = neg ? (q - p) : (p - q);

      num_in[LANE_SAT] = {d, 16'd0};
      if (grey)
         den_in[LANE_SAT] = 8'd1;
      else if (sum <= 9'd255)
         den_in[LANE_SAT] = sum[7:0];
      else
         den_in[LANE_SAT] = 8'(9'd510 - sum);

      // 7680*diff, plus d-1 to round the negative side up
      num_in[LANE_HUE] = {3'd0, diff, 13'd0} - {7'd0, diff, 9'd0}
                         + (neg ? {16'd0, 8'(d - 8'd1)} : 24'd0);
      den_in[LANE_HUE] = grey ? 8'd1 : d;

      l_prod = {25'd0, sum} * {9'd0, L_RECIP};
      side_in.hue_sel = sel;
      side_in.neg     = neg;
      side_in.light   = l_prod[33:17];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_num   = num_ff;
   assign dn_den   = den_ff;
   assign dn_side  = side_ff;

endmodule

FILE: hw/rtl/hcs_div.sv
module hcs_div import hcs_pkg::*; (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  up_valid,
   input  logic [DIV_LANES-1:0][DIV_NUM_W-1:0]   up_num,
   input  logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   up_den,
   input  hcs_side_type                          up_side,
   output logic                                  dn_valid,
   output logic [DIV_LANES-1:0][DIV_QUO_W-1:0]   dn_quo,
   output hcs_side_type                          dn_side
);

   // one quotient bit per stage; numerator must be below den << DIV_QUO_W
   logic [DIV_QUO_W-1:0] valid_ff;
   hcs_side_type         side_ff [DIV_QUO_W];
   logic [DIV_DEN_W-1:0] rem_ff  [DIV_LANES][DIV_QUO_W];
   logic [DIV_DEN_W-1:0] rem_in  [DIV_LANES][DIV_QUO_W];
   logic [DIV_DEN_W-1:0] den_ff  [DIV_LANES][DIV_QUO_W];
   logic [DIV_DEN_W-1:0] den_in  [DIV_LANES][DIV_QUO_W];
   logic [DIV_QUO_W-1:0] work_ff [DIV_LANES][DIV_QUO_W];
   logic [DIV_QUO_W-1:0] work_in [DIV_LANES][DIV_QUO_W];

   for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
      for (genvar s = 0; s < DIV_QUO_W; s++) begin : g_stage
         logic [DIV_DEN_W-1:0] rem_src, den_src;
         logic [DIV_QUO_W-1:0] work_src;
         logic [DIV_DEN_W:0]   trial;
         logic                 hit;
         if (s == 0) begin : g_first
            assign rem_src  = DIV_DEN_W'(up_num[l][DIV_NUM_W-1:DIV_QUO_W]);
            assign work_src = up_num[l][DIV_QUO_W-1:0];
            assign den_src  = up_den[l];
         end else begin : g_next
            assign rem_src  = rem_ff[l][s-1];
            assign work_src = work_ff[l][s-1];
            assign den_src  = den_ff[l][s-1];
         end
         always_comb begin
            trial = {rem_src, work_src[DIV_QUO_W-1]};
            hit   = (trial >= {1'b0, den_src});
            rem_in[l][s]  = hit ? DIV_DEN_W'(trial - {1'b0, den_src})
                                : trial[DIV_DEN_W-1:0];
            work_in[l][s] = {work_src[DIV_QUO_W-2:0], hit};
            den_in[l][s]  = den_src;
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[l][s]  <= rem_in[l][s];
               work_ff[l][s] <= work_in[l][s];
               den_ff[l][s]  <= den_in[l][s];
            end
         end
      end
      assign dn_quo[l] = work_ff[l][DIV_QUO_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_QUO_W-2:0], up_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= up_side;
         for (int s = 1; s < DIV_QUO_W; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign dn_valid = valid_ff[DIV_QUO_W-1];
   assign dn_side  = side_ff[DIV_QUO_W-1];

endmodule

FILE: hw/rtl/hcs_back.sv
module hcs_back import hcs_pkg::*; (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic [GAIN_W-1:0]                     light_gain,
   input  logic [GAIN_W-1:0]                     sat_gain,
   input  logic                                  lighten_mode,
   input  logic                                  up_valid,
   input  logic [DIV_LANES-1:0][DIV_QUO_W-1:0]   up_quo,
   input  hcs_side_type                          up_side,
   output logic                                  dn_valid,
   output logic [PIX_W-1:0]                      dn_pixel
);

   localparam int NSTAGE = 7;

   logic [NSTAGE-1:0] valid_ff;

   // hue and scaling products
   logic signed [17:0] hue_c;
   logic [HUE_W-1:0]   base_c;
   logic [FRAC_W-1:0]  lx_c, sx_c;
   logic [HUE_W-1:0]   hue_c_ff, hue_d_ff, hue_e_ff;
   logic [32:0]        pl_c_ff, ps_c_ff, pl_c_in, ps_c_in;

   // clamp and unfold
   logic [FRAC_W-1:0]  lcl_d, scl_d, l_d_in, s_d_in, l_d_ff, s_d_ff;

   // m2 product
   logic [FRAC_W-1:0]  a_e;
   logic [33:0]        pm_e_in, pm_e_ff;
   logic [FRAC_W-1:0]  l_e_ff;

   // m1, m2 and channel hues
   logic [FRAC_W:0]    m2_w, m1_w;
   logic [FRAC_W-1:0]  m1_f_ff, m2_f_ff, m1_g_ff, m2_g_ff;
   logic [HUE_W-1:0]   hue_f_in [NUM_CHAN];
   logic [HUE_W-1:0]   hue_f_ff [NUM_CHAN];

   // mix products
   logic [FRAC_W-1:0]  dm_g;
   logic [12:0]        t_g      [NUM_CHAN];
   hcs_seg_type        seg_g_in [NUM_CHAN];
   hcs_seg_type        seg_g_ff [NUM_CHAN];
   logic [29:0]        mp_g_in  [NUM_CHAN];
   logic [29:0]        mp_g_ff  [NUM_CHAN];

   // divide by 7680 and select
   logic [42:0]        qq_h     [NUM_CHAN];
   logic [FRAC_W-1:0]  v_h_in   [NUM_CHAN];
   logic [FRAC_W-1:0]  v_h_ff   [NUM_CHAN];

   // byte conversion
   logic [24:0]        bw_i     [NUM_CHAN];
   logic [PIX_W-1:0]   pix_in, pix_ff;

   always_comb begin
      case (up_side.hue_sel)
         HUE_RED:   base_c = '0;
         HUE_GREEN: base_c = DEG120;
         HUE_BLUE:  base_c = DEG240;
         default:   base_c = '0;
      endcase
      hue_c = up_side.neg
              ? signed'({2'b00, base_c}) - signed'({1'b0, up_quo[LANE_HUE]})
              : signed'({2'b00, base_c}) + signed'({1'b0, up_quo[LANE_HUE]});
      if (hue_c < 0) hue_c = hue_c + signed'({2'b00, DEG360});
      lx_c = lighten_mode ? FRAC_ONE - up_side.light : up_side.light;
      sx_c = lighten_mode ? FRAC_ONE - up_quo[LANE_SAT] : up_quo[LANE_SAT];
      pl_c_in = {16'd0, lx_c} * {17'd0, light_gain};
      ps_c_in = {16'd0, sx_c} * {17'd0, sat_gain};
   end

   always_comb begin
      lcl_d  = (pl_c_ff[32:12] > 21'(FRAC_ONE)) ? FRAC_ONE : pl_c_ff[28:12];
      scl_d  = (ps_c_ff[32:12] > 21'(FRAC_ONE)) ? FRAC_ONE : ps_c_ff[28:12];
      l_d_in = lighten_mode ? FRAC_ONE - lcl_d : lcl_d;
      s_d_in = lighten_mode ? FRAC_ONE - scl_d : scl_d;
   end

   always_comb begin
      a_e     = (l_d_ff <= FRAC_HALF) ? l_d_ff : FRAC_ONE - l_d_ff;
      pm_e_in = {17'd0, a_e} * {17'd0, s_d_ff};
   end

   always_comb begin
      logic signed [17:0] raw;
      m2_w = {1'b0, l_e_ff} + {1'b0, pm_e_ff[32:16]};
      m1_w = {l_e_ff, 1'b0} - m2_w;
      for (int c = 0; c < NUM_CHAN; c++) begin
         case (c)
            0:       raw = signed'({2'b00, hue_e_ff}) + signed'({2'b00, DEG120});
            2:       raw = signed'({2'b00, hue_e_ff}) - signed'({2'b00, DEG120});
            default: raw = signed'({2'b00, hue_e_ff});
         endcase
         if (raw > signed'({2'b00, DEG360})) raw = raw - signed'({2'b00, DEG360});
         if (raw < 0) raw = raw + signed'({2'b00, DEG360});
         hue_f_in[c] = raw[HUE_W-1:0];
      end
   end

   always_comb begin
      dm_g = m2_f_ff - m1_f_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (hue_f_ff[c] < DEG60) begin
            seg_g_in[c] = SEG_RISE;
            t_g[c]      = hue_f_ff[c][12:0];
         end else if (hue_f_ff[c] < DEG180) begin
            seg_g_in[c] = SEG_HIGH;
            t_g[c]      = '0;
         end else if (hue_f_ff[c] < DEG240) begin
            seg_g_in[c] = SEG_FALL;
            t_g[c]      = 13'(DEG240 - hue_f_ff[c]);
         end else begin
            seg_g_in[c] = SEG_LOW;
            t_g[c]      = '0;
         end
         mp_g_in[c] = {13'd0, dm_g} * {17'd0, t_g[c]};
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         qq_h[c] = {22'd0, mp_g_ff[c][29:9]} * {21'd0, DIV15_RECIP};
         case (seg_g_ff[c])
            SEG_RISE, SEG_FALL: v_h_in[c] = m1_g_ff + qq_h[c][41:25];
            SEG_HIGH:           v_h_in[c] = m2_g_ff;
            SEG_LOW:            v_h_in[c] = m1_g_ff;
            default:            v_h_in[c] = m1_g_ff;
         endcase
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         bw_i[c] = {v_h_ff[c], 8'd0} - {8'd0, v_h_ff[c]} + 25'd255;
         pix_in[PIX_W-1-8*c -: 8] = (bw_i[c][24:16] > 9'd255) ? 8'd255 : bw_i[c][23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NSTAGE-2:0], up_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_c_ff <= hue_c[HUE_W-1:0];
         pl_c_ff  <= pl_c_in;
         ps_c_ff  <= ps_c_in;
         hue_d_ff <= hue_c_ff;
         l_d_ff   <= l_d_in;
         s_d_ff   <= s_d_in;
         hue_e_ff <= hue_d_ff;
         l_e_ff   <= l_d_ff;
         pm_e_ff  <= pm_e_in;
         m1_f_ff  <= m1_w[FRAC_W-1:0];
         m2_f_ff  <= m2_w[FRAC_W-1:0];
         m1_g_ff  <= m1_f_ff;
         m2_g_ff  <= m2_f_ff;
         for (int c = 0; c < NUM_CHAN; c++) begin
            hue_f_ff[c] <= hue_f_in[c];
            seg_g_ff[c] <= seg_g_in[c];
            mp_g_ff[c]  <= mp_g_in[c];
            v_h_ff[c]   <= v_h_in[c];
         end
         pix_ff <= pix_in;
      end
   end

   assign dn_valid = valid_ff[NSTAGE-1];
   assign dn_pixel = pix_ff;

endmodule

FILE: tb/hls_color_shade_top_tb.sv
`timescale 1ns / 1ps

module hls_color_shade_top_tb;
   import hcs_pkg::*;

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [GAIN_W-1:0] csr_wdata;

   hcs_req_if req_if();
   hcs_rsp_if rsp_if();

   hls_color_shade_top uut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [23:0] pixel_queue[$];
   int unsigned errors;
   logic [15:0] light_gain_q;
   logic [15:0] sat_gain_q;
   logic        lighten_q;
   bit          rsp_random;

   always #5 clock = ~clock;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_LIGHT_GAIN;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.pixel_in = '0;
      rsp_if.ready = 1'b0;
      errors = 0;
      rsp_random = 1'b0;
      light_gain_q = GAIN_UNITY;
      sat_gain_q = GAIN_UNITY;
      lighten_q = 1'b0;
   end

   function automatic int unsigned gap_len();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int hue_piece(int base, int p, int q, int d);
      if (p >= q) return base + (7680 * (p - q)) / d;
      return base - (7680 * (q - p) + d - 1) / d;
   endfunction

   function automatic longint scale_frac(longint x, longint g);
      longint v;
      v = (x * g) >>> 12;
      return (v > 65536) ? 65536 : v;
   endfunction

   function automatic logic [7:0] chan_byte(int h, longint m1, longint m2);
      longint v;
      longint b;
      if (h > 46080) h -= 46080;
      if (h < 0) h += 46080;
      if (h < 7680) v = m1 + ((m2 - m1) * h) / 7680;
      else if (h < 23040) v = m2;
      else if (h < 30720) v = m1 + ((m2 - m1) * (30720 - h)) / 7680;
      else v = m1;
      b = (v * 255 + 255) >>> 16;
      return (b > 255) ? 8'd255 : b[7:0];
   endfunction

   function automatic logic [23:0] shade_pixel(logic [23:0] px);
      int r, g, b, mx, mn, sum, d, h;
      longint l, s, m1, m2;
      r = px[23:16]; g = px[15:8]; b = px[7:0];
      mx = (r > g) ? r : g; if (b > mx) mx = b;
      mn = (r < g) ? r : g; if (b < mn) mn = b;
      sum = mx + mn;
      l = (longint'(sum) * 65536) / 510;
      s = 0; h = 0;
      if (mx != mn) begin
         d = mx - mn;
         if (sum <= 255) s = (longint'(d) * 65536) / sum;
         else s = (longint'(d) * 65536) / (510 - sum);
         if (r == mx) begin
            h = hue_piece(0, g, b, d);
            if (h < 0) h += 46080;
         end else if (g == mx) h = hue_piece(15360, b, r, d);
         else h = hue_piece(30720, r, g, d);
      end
      if (lighten_q) begin
         l = 65536 - scale_frac(65536 - l, light_gain_q);
         s = 65536 - scale_frac(65536 - s, sat_gain_q);
      end else begin
         l = scale_frac(l, light_gain_q);
         s = scale_frac(s, sat_gain_q);
      end
      if (l <= 32768) m2 = l + ((l * s) >>> 16);
      else m2 = l + ((s * (65536 - l)) >>> 16);
      m1 = 2 * l - m2;
      return {chan_byte(h + 15360, m1, m2), chan_byte(h, m1, m2),
              chan_byte(h - 15360, m1, m2)};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pixel_queue.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_if.pixel_out);
               errors++;
            end else begin
               if (rsp_if.pixel_out !== pixel_queue[0]) begin
                  $display("%0t: pixel_out expected %h actual %h", $time,
                           pixel_queue[0], rsp_if.pixel_out);
                  errors++;
               end
               void'(pixel_queue.pop_front());
            end
         end
         rsp_if.ready <= rsp_random ? ($urandom_range(0, 99) < 70) : 1'b1;
      end
   end

   task automatic send_pixel(logic [23:0] px);
      int unsigned n;
      n = gap_len();
      if (n != 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.pixel_in <= px;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pixel_queue.push_back(shade_pixel(px));
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(hcs_csr_type idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LIGHT_GAIN: light_gain_q = val;
         CSR_SAT_GAIN: sat_gain_q = val;
         default: lighten_q = val[0];
      endcase
   endtask

   task automatic set_shade(logic [15:0] lg, logic [15:0] sg, logic mode);
      drain();
      write_csr(CSR_LIGHT_GAIN, lg);
      write_csr(CSR_SAT_GAIN, sg);
      write_csr(CSR_LIGHTEN_MODE, {15'd0, mode});
   endtask

   task automatic test_directed();
      logic [23:0] pix[] = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000,
         24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
         24'hFF0001, 24'h7F3F10, 24'h10203F, 24'hAA55AA, 24'h010000,
         24'hFEFFFF, 24'h123456, 24'hC0FFEE, 24'h5A5A5B, 24'hFF8000};
      foreach (pix[i]) send_pixel(pix[i]);
   endtask

   task automatic test_random(int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_pixel({3{8'($urandom_range(0, 255))}});
         else
            send_pixel(24'($urandom));
      end
   endtask

   task automatic test_settings();
      set_shade(16'd0, 16'd0, 1'b0);
      test_directed();
      set_shade(16'hFFFF, 16'hFFFF, 1'b1);
      test_directed();
      set_shade(16'hFFFF, 16'd0, 1'b0);
      test_random(60);
      set_shade(16'd0, 16'hFFFF, 1'b1);
      test_random(60);
      repeat (6) begin
         set_shade(16'($urandom_range(0, 12288)), 16'($urandom),
                   1'($urandom_range(0, 1)));
         test_random(80);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      rsp_random = 1'b1;
      test_random(60);
      test_settings();
      set_shade(GAIN_UNITY, GAIN_UNITY, 1'b0);
      test_random(40);
      drain();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
